FILE: rtl/qra_pkg.sv
`timescale 1ns / 1ps

package qra_pkg;

  // Fixed-point format of every quaternion component and matrix entry.
  localparam int FRAC_BITS = 14;
  localparam int DATA_W    = 16;
  localparam int PROD_W    = 2 * DATA_W;
  // Wide enough for four full-scale products, or one plus two doubled products.
  localparam int ACC_W     = PROD_W + 3;

  localparam logic signed [DATA_W-1:0] ONE_Q    = DATA_W'(1 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0]  ROUND_C  = ACC_W'(64'sd1 << (FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0]  ONE2_C   = ACC_W'(64'sd1 << (2 * FRAC_BITS));
  localparam logic signed [ACC_W-1:0]  SAT_MAX  = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0]  SAT_MIN  = ACC_W'(-32768);

  // Sequencer program length: 16 Hamilton products, one gap, 18 matrix products.
  localparam int STEP_W    = 6;
  localparam int NUM_STEPS = 35;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);
  localparam int NUM_ENTRIES = 9;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_e;

  // Multiplier operand sources: stored, incoming and new quaternion.
  typedef enum logic [3:0] {
    O_W, O_X, O_Y, O_Z,
    I_W, I_X, I_Y, I_Z,
    N_W, N_X, N_Y, N_Z
  } opnd_e;

  // Destinations of a finished sum.
  typedef enum logic [3:0] {
    D_R00, D_R01, D_R02,
    D_R10, D_R11, D_R12,
    D_R20, D_R21, D_R22,
    D_NW, D_NX, D_NY, D_NZ
  } dest_e;

  typedef struct packed {
    logic  valid;
    opnd_e a;
    opnd_e b;
    logic  neg;
    logic  dbl;
    logic  init;
    logic  one;
    logic  last;
    dest_e dest;
  } uop_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic load_out;
    uop_t uop;
  } cmd_t;

  function automatic uop_t mk(opnd_e a, opnd_e b, logic neg, logic dbl, logic init,
                              logic one, logic last, dest_e dest);
    uop_t u;
    u.valid = 1'b1;
    u.a     = a;
    u.b     = b;
    u.neg   = neg;
    u.dbl   = dbl;
    u.init  = init;
    u.one   = one;
    u.last  = last;
    u.dest  = dest;
    return u;
  endfunction

  // Program of the shared multiply-accumulate unit, one product per step.
  function automatic uop_t ucode(logic [STEP_W-1:0] step);
    uop_t u;
    u = '0;
    case (step)
      // x of the product
      6'd0:  u = mk(O_W, I_X, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, D_NX);
      6'd1:  u = mk(O_X, I_W, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, D_NX);
      6'd2:  u = mk(O_Y, I_Z, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, D_NX);
      6'd3:  u = mk(O_Z, I_Y, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, D_NX);
      // y of the product
      6'd4:  u = mk(O_W, I_Y, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, D_NY);
      6'd5:  u = mk(O_Y, I_W, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, D_NY);
      6'd6:  u = mk(O_Z, I_X, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, D_NY);
      6'd7:  u = mk(O_X, I_Z, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, D_NY);
      // z of the product
      6'd8:  u = mk(O_W, I_Z, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, D_NZ);
      6'd9:  u = mk(O_Z, I_W, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, D_NZ);
      6'd10: u = mk(O_X, I_Y, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, D_NZ);
      6'd11: u = mk(O_Y, I_X, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, D_NZ);
      // w of the product
      6'd12: u = mk(O_W, I_W, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, D_NW);
      6'd13: u = mk(O_X, I_X, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, D_NW);
      6'd14: u = mk(O_Y, I_Y, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, D_NW);
      6'd15: u = mk(O_Z, I_Z, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, D_NW);
      // Step 16 is a gap so the last component lands before the matrix reads it.
      6'd17: u = mk(N_Y, N_Y, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, D_R00);
      6'd18: u = mk(N_Z, N_Z, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, D_R00);
      6'd19: u = mk(N_X, N_Y, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, D_R01);
      6'd20: u = mk(N_Z, N_W, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, D_R01);
      6'd21: u = mk(N_X, N_Z, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, D_R02);
      6'd22: u = mk(N_Y, N_W, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, D_R02);
      6'd23: u = mk(N_X, N_Y, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, D_R10);
      6'd24: u = mk(N_Z, N_W, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, D_R10);
      6'd25: u = mk(N_X, N_X, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, D_R11);
      6'd26: u = mk(N_Z, N_Z, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, D_R11);
      6'd27: u = mk(N_Y, N_Z, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, D_R12);
      6'd28: u = mk(N_X, N_W, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, D_R12);
      6'd29: u = mk(N_X, N_Z, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, D_R20);
      6'd30: u = mk(N_Y, N_W, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, D_R20);
      6'd31: u = mk(N_Y, N_Z, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, D_R21);
      6'd32: u = mk(N_X, N_W, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, D_R21);
      6'd33: u = mk(N_X, N_X, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, D_R22);
      6'd34: u = mk(N_Y, N_Y, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, D_R22);
      default: u = '0;
    endcase
    return u;
  endfunction

endpackage

FILE: rtl/qra_ctrl.sv
`timescale 1ns / 1ps

module qra_ctrl import qra_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;

  // State, step counter and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          step_d        = '0;
          state_d       = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.uop = ucode(step_q);
        if (step_q == LAST_STEP) begin
          state_d = S_DRAIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DRAIN: begin
        // The new quaternion is complete; it becomes the stored orientation.
        cmd_o.commit = 1'b1;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // The output register holds its request until it is taken.
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while its request waits");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_RUN && step_q == '0))
    else $error("accepted request did not start the program at step zero");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (step_q <= LAST_STEP))
    else $error("step counter ran past the program");

  a_run_to_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && step_q == LAST_STEP) |=> (state_q == S_DRAIN))
    else $error("program end did not drain the accumulator");

endmodule

FILE: rtl/qra_datapath.sv
`timescale 1ns / 1ps

module qra_datapath import qra_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  input  logic signed [DATA_W-1:0] in_w_i,
  input  logic signed [DATA_W-1:0] in_x_i,
  input  logic signed [DATA_W-1:0] in_y_i,
  input  logic signed [DATA_W-1:0] in_z_i,
  output logic signed [DATA_W-1:0] res_o [NUM_ENTRIES]
);

  logic signed [DATA_W-1:0] orient_q [4];
  logic signed [DATA_W-1:0] in_q     [4];
  logic signed [DATA_W-1:0] nq_q     [4];
  logic signed [DATA_W-1:0] work_q   [NUM_ENTRIES];
  logic signed [DATA_W-1:0] out_q    [NUM_ENTRIES];

  logic signed [DATA_W-1:0] opa, opb;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  uop_t                     pipe_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d, term, base, shifted;
  logic signed [DATA_W-1:0] sat;

  function automatic logic signed [DATA_W-1:0] pick(
      opnd_e sel,
      logic signed [DATA_W-1:0] o [4],
      logic signed [DATA_W-1:0] i [4],
      logic signed [DATA_W-1:0] n [4]);
    logic signed [DATA_W-1:0] v;
    case (sel)
      O_W: v = o[0];
      O_X: v = o[1];
      O_Y: v = o[2];
      O_Z: v = o[3];
      I_W: v = i[0];
      I_X: v = i[1];
      I_Y: v = i[2];
      I_Z: v = i[3];
      N_W: v = n[0];
      N_X: v = n[1];
      N_Y: v = n[2];
      N_Z: v = n[3];
      default: v = '0;
    endcase
    return v;
  endfunction

  // Operand selection and the shared multiplier.
  assign opa    = pick(cmd_i.uop.a, orient_q, in_q, nq_q);
  assign opb    = pick(cmd_i.uop.b, orient_q, in_q, nq_q);
  assign prod_d = opa * opb;

  // Accumulate stage: scale and sign the product, add to the running sum.
  always_comb begin
    term = ACC_W'(prod_q);
    if (pipe_q.dbl) begin
      term = term <<< 1;
    end
    if (pipe_q.neg) begin
      term = -term;
    end
    base = pipe_q.one ? (ROUND_C + ONE2_C) : ROUND_C;
    acc_d = (pipe_q.init ? base : acc_q) + term;
  end

  // The rounding offset sits in the seed, so reduction is a floor shift and a clip.
  always_comb begin
    shifted = acc_d >>> FRAC_BITS;
    if (shifted > SAT_MAX) begin
      sat = DATA_W'(SAT_MAX);
    end else if (shifted < SAT_MIN) begin
      sat = DATA_W'(SAT_MIN);
    end else begin
      sat = shifted[DATA_W-1:0];
    end
  end

  // Pipeline control and the stored orientation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_q      <= '0;
      orient_q[0] <= ONE_Q;
      orient_q[1] <= '0;
      orient_q[2] <= '0;
      orient_q[3] <= '0;
    end else begin
      pipe_q <= cmd_i.uop;
      if (cmd_i.commit) begin
        orient_q <= nq_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q[0] <= in_w_i;
      in_q[1] <= in_x_i;
      in_q[2] <= in_y_i;
      in_q[3] <= in_z_i;
    end
    prod_q <= prod_d;
    if (pipe_q.valid) begin
      acc_q <= acc_d;
      if (pipe_q.last) begin
        case (pipe_q.dest)
          D_NW:    nq_q[0] <= sat;
          D_NX:    nq_q[1] <= sat;
          D_NY:    nq_q[2] <= sat;
          D_NZ:    nq_q[3] <= sat;
          default: work_q[4'(pipe_q.dest)] <= sat;
        endcase
      end
    end
    if (cmd_i.load_out) begin
      out_q <= work_q;
    end
  end

  assign res_o = out_q;

endmodule

FILE: rtl/quaternion_rotation_accumulator_unit.sv
`timescale 1ns / 1ps

// Keeps an orientation quaternion (reset to identity), multiplies it on the
// right by each incoming quaternion, stores the saturated product and returns
// the 3x3 rotation matrix of the new orientation. All values are 16-bit signed
// fixed point with FRAC_BITS fraction bits. After a request is accepted, a
// single shared 16x16 multiply-accumulate unit walks 34 products in program
// order, with one gap step; a drain state then empties its pipeline register
// and a finish state loads the result into the output register. The next
// request is accepted in the cycle after the load, so no request is taken
// while an earlier one is still being computed. A new request is accepted
// while the previous result still waits at the output; the load of its
// result then waits until the earlier result has been taken.
module quaternion_rotation_accumulator_unit import qra_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DATA_W-1:0] in_w_i,
  input  logic signed [DATA_W-1:0] in_x_i,
  input  logic signed [DATA_W-1:0] in_y_i,
  input  logic signed [DATA_W-1:0] in_z_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] r00_o,
  output logic signed [DATA_W-1:0] r01_o,
  output logic signed [DATA_W-1:0] r02_o,
  output logic signed [DATA_W-1:0] r10_o,
  output logic signed [DATA_W-1:0] r11_o,
  output logic signed [DATA_W-1:0] r12_o,
  output logic signed [DATA_W-1:0] r20_o,
  output logic signed [DATA_W-1:0] r21_o,
  output logic signed [DATA_W-1:0] r22_o
);

  cmd_t                     cmd;
  logic signed [DATA_W-1:0] res [NUM_ENTRIES];

  // Sequencer.
  qra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Multiply-accumulate datapath and result registers.
  qra_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .in_w_i (in_w_i),
    .in_x_i (in_x_i),
    .in_y_i (in_y_i),
    .in_z_i (in_z_i),
    .res_o  (res)
  );

  assign r00_o = res[0];
  assign r01_o = res[1];
  assign r02_o = res[2];
  assign r10_o = res[3];
  assign r11_o = res[4];
  assign r12_o = res[5];
  assign r20_o = res[6];
  assign r21_o = res[7];
  assign r22_o = res[8];

endmodule
